>>> src/sum16_packet_deframer_unit_defines.svh
// ----------------------------------------------------------------------------
// sum16_packet_deframer_unit_defines.svh
// Assertion macros shared by the deframer checker.
// ----------------------------------------------------------------------------
`ifndef SUM16_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define SUM16_PACKET_DEFRAMER_UNIT_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define SPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> src/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared constants and codes for the sum16 packet deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int MAX_PAYLOAD = 256;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int OUT_LEN_W = 9;
    localparam int ADDR_W   = 32;
    localparam int TAG_W    = 16;
    localparam int LEN_W    = 16;
    localparam int SUM_W    = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    // Minimum buffer length for a complete frame and header length.
    localparam int MIN_BUFFER   = 11;
    localparam int HEADER_BYTES = 9;

    localparam int BCNT_W = $clog2(MIN_BUFFER + 1);
    localparam int PCNT_W = $clog2(MAX_PAYLOAD + 1);

    localparam logic [ADDR_W-1:0] ADDR_RESET = 32'hFFFF_FFFF;
    localparam logic [TAG_W-1:0]  TAG_RESET  = 16'hEF01;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TAG        = 1'd1;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FRAME_ERROR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_PACKET  = 2'd2;

endpackage

>>> src/sum16_packet_deframer_unit.sv
// ----------------------------------------------------------------------------
// sum16_packet_deframer_unit
// Byte-stream deframer for tagged, addressed packets with a 16-bit sum check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*) carries one received byte per item plus a flag that
//   marks the last byte of the buffer. Result channel (m_*) carries either a
//   payload byte (kind 0) or the final status of the frame (kind 1).
//   The configuration port (cfg_wr_en/cfg_index/cfg_data) loads the expected
//   address and the frame tag; write it only while the block is idle.
//   Path: input register, then parse into the result register once it is
//   free or being drained. Throughput: one item per cycle while m_ready is
//   high. The parse is a single pass of running sum, counters and compares
//   between the input and result registers.
//   Reset: clears both valid flags, returns the parser to the header phase
//   and loads the register reset values (address all ones, tag 0xEF01).
//   Stall: while m_ready is low a pending result holds in the output
//   register; one more item may enter the input register, then s_ready drops
//   until the result is taken.
// ----------------------------------------------------------------------------
module sum16_packet_deframer_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [spd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spd_pkg::CFG_W-1:0]       cfg_data,
    // input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [spd_pkg::BYTE_W-1:0]      s_rx_byte,
    input  logic                            s_buffer_end,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_kind,
    output logic [spd_pkg::BYTE_W-1:0]      m_payload_byte,
    output logic [spd_pkg::STATUS_W-1:0]    m_status,
    output logic [spd_pkg::BYTE_W-1:0]      m_packet_type,
    output logic [spd_pkg::OUT_LEN_W-1:0]   m_payload_length,
    output logic [spd_pkg::OUT_LEN_W-1:0]   m_frame_bytes
);
    import spd_pkg::*;

    // Parser phases, one-hot.
    typedef enum logic [5:0] {
        PH_HEADER     = 6'b000001,
        PH_PAYLOAD    = 6'b000010,
        PH_CK_HIGH    = 6'b000100,
        PH_CK_LOW     = 6'b001000,
        PH_FAULT_WAIT = 6'b010000,
        PH_DISCARD    = 6'b100000
    } phase_t;

    // Header byte positions (1-based count after the byte is taken).
    localparam logic [BCNT_W-1:0] POS_TAG_END  = BCNT_W'(2);
    localparam logic [BCNT_W-1:0] POS_ADDR_END = BCNT_W'(6);
    localparam logic [BCNT_W-1:0] POS_TYPE     = BCNT_W'(7);
    localparam logic [BCNT_W-1:0] POS_LEN_HI   = BCNT_W'(8);
    localparam logic [BCNT_W-1:0] POS_LEN_LO   = BCNT_W'(9);
    localparam logic [BCNT_W-1:0] BCNT_SAT     = BCNT_W'(MIN_BUFFER);
    localparam logic [LEN_W-1:0]  LEN_MIN      = LEN_W'(2);
    localparam logic [LEN_W-1:0]  LEN_MAX      = LEN_W'(MAX_PAYLOAD + 2);
    localparam logic [LEN_W-1:0]  LEN_HDR      = LEN_W'(HEADER_BYTES);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] exp_addr_reg;
    logic [TAG_W-1:0]  tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_addr_reg <= ADDR_RESET;
            tag_reg      <= TAG_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_EXPECTED_ADDRESS: exp_addr_reg <= cfg_data[ADDR_W-1:0];
                REG_FRAME_TAG:        tag_reg      <= cfg_data[TAG_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_end_reg;
    logic              out_valid_reg;
    logic              advance;

    // Parse the held item when the result register is free or being drained.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
            in_end_reg  <= s_buffer_end;
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    phase_t            phase_reg,        phase_next;
    logic [BCNT_W-1:0] byte_count_reg,   byte_count_next;
    logic              fault_reg,        fault_next;
    logic [ADDR_W-1:0] hdr_shift_reg,    hdr_shift_next;
    logic [PCNT_W-1:0] pay_count_reg,    pay_count_next;
    logic [BYTE_W-1:0] type_reg,         type_next;
    logic [LEN_W-1:0]  length_reg,       length_next;
    logic [SUM_W-1:0]  sum_reg,          sum_next;
    logic [BYTE_W-1:0] ck_high_reg,      ck_high_next;

    // Result of the current item
    logic                 res_valid;
    logic                 res_kind;
    logic [BYTE_W-1:0]    res_byte;
    logic [STATUS_W-1:0]  res_status;
    logic [BYTE_W-1:0]    res_type;
    logic [OUT_LEN_W-1:0] res_plen;
    logic [OUT_LEN_W-1:0] res_fbytes;

    // Parse helpers
    logic [BCNT_W-1:0] bcnt_inc;
    logic              short_buf;
    logic              check_end;
    logic              payload_out;
    logic              restart;
    logic [ADDR_W-1:0] shifted;
    logic [LEN_W-1:0]  len_full;
    logic [PCNT_W-1:0] pay_inc;

    always_comb begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        fault_next      = fault_reg;
        hdr_shift_next  = hdr_shift_reg;
        pay_count_next  = pay_count_reg;
        type_next       = type_reg;
        length_next     = length_reg;
        sum_next        = sum_reg;
        ck_high_next    = ck_high_reg;

        res_valid  = 1'b0;
        res_kind   = KIND_PAYLOAD;
        res_byte   = '0;
        res_status = STATUS_OK;
        res_type   = '0;
        res_plen   = '0;
        res_fbytes = '0;

        check_end   = 1'b0;
        payload_out = 1'b0;
        restart     = 1'b0;

        // Byte count saturates once the buffer is long enough to matter.
        bcnt_inc  = (byte_count_reg >= BCNT_SAT) ? byte_count_reg
                                                 : byte_count_reg + BCNT_W'(1);
        short_buf = bcnt_inc < BCNT_SAT;
        shifted   = {hdr_shift_reg[ADDR_W-BYTE_W-1:0], in_byte_reg};
        len_full  = {length_reg[LEN_W-1:BYTE_W], in_byte_reg};
        pay_inc   = pay_count_reg + PCNT_W'(1);

        case (phase_reg)
            PH_DISCARD: begin
                // Drop bytes until the buffer ends.
                restart = in_end_reg;
            end
            PH_HEADER: begin
                byte_count_next = bcnt_inc;
                check_end       = 1'b1;
                if (bcnt_inc <= POS_ADDR_END) begin
                    hdr_shift_next = shifted;
                end
                if (bcnt_inc == POS_TAG_END && shifted[TAG_W-1:0] != tag_reg) begin
                    fault_next = 1'b1;
                end
                if (bcnt_inc == POS_ADDR_END && shifted != exp_addr_reg) begin
                    fault_next = 1'b1;
                end
                if (bcnt_inc == POS_TYPE) begin
                    type_next = in_byte_reg;
                end
                if (bcnt_inc == POS_LEN_HI) begin
                    length_next = {in_byte_reg, {BYTE_W{1'b0}}};
                end
                if (bcnt_inc == POS_LEN_LO) begin
                    length_next    = len_full;
                    pay_count_next = '0;
                    sum_next       = SUM_W'(type_reg) + SUM_W'(len_full[LEN_W-1:BYTE_W])
                                   + SUM_W'(in_byte_reg);
                    if (fault_reg || len_full < LEN_MIN || len_full > LEN_MAX) begin
                        fault_next = 1'b1;
                        phase_next = PH_FAULT_WAIT;
                    end else if (len_full == LEN_MIN) begin
                        phase_next = PH_CK_HIGH;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                byte_count_next = bcnt_inc;
                check_end       = 1'b1;
                payload_out     = 1'b1;
                sum_next        = sum_reg + SUM_W'(in_byte_reg);
                pay_count_next  = pay_inc;
                if (LEN_W'(pay_inc) >= length_reg - LEN_MIN) begin
                    phase_next = PH_CK_HIGH;
                end
            end
            PH_CK_HIGH: begin
                byte_count_next = bcnt_inc;
                check_end       = 1'b1;
                ck_high_next    = in_byte_reg;
                phase_next      = PH_CK_LOW;
            end
            PH_CK_LOW: begin
                byte_count_next = bcnt_inc;
                res_valid       = 1'b1;
                res_kind        = KIND_STATUS;
                if ({ck_high_reg, in_byte_reg} == sum_reg) begin
                    res_status = STATUS_OK;
                    res_type   = type_reg;
                    res_plen   = OUT_LEN_W'(length_reg - LEN_MIN);
                    res_fbytes = OUT_LEN_W'(length_reg + LEN_HDR);
                end else begin
                    res_status = STATUS_BAD_PACKET;
                end
                phase_next = PH_DISCARD;
                restart    = in_end_reg;
            end
            PH_FAULT_WAIT: begin
                byte_count_next = bcnt_inc;
                if (!short_buf) begin
                    res_valid  = 1'b1;
                    res_kind   = KIND_STATUS;
                    res_status = STATUS_BAD_PACKET;
                    phase_next = PH_DISCARD;
                    restart    = in_end_reg;
                end else begin
                    check_end = 1'b1;
                end
            end
            default: begin
                phase_next = PH_HEADER;
            end
        endcase

        // Buffer ends inside the frame: status replaces any payload byte.
        if (check_end && in_end_reg) begin
            res_valid  = 1'b1;
            res_kind   = KIND_STATUS;
            res_status = short_buf ? STATUS_FRAME_ERROR : STATUS_BAD_PACKET;
            restart    = 1'b1;
        end else if (payload_out) begin
            res_valid = 1'b1;
            res_byte  = in_byte_reg;
        end

        if (restart) begin
            phase_next      = PH_HEADER;
            byte_count_next = '0;
            fault_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            byte_count_reg <= '0;
            fault_reg      <= 1'b0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            fault_reg      <= fault_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            hdr_shift_reg <= hdr_shift_next;
            pay_count_reg <= pay_count_next;
            type_reg      <= type_next;
            length_reg    <= length_next;
            sum_reg       <= sum_next;
            ck_high_reg   <= ck_high_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                 out_kind_reg;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [BYTE_W-1:0]    out_type_reg;
    logic [OUT_LEN_W-1:0] out_plen_reg;
    logic [OUT_LEN_W-1:0] out_fbytes_reg;
    logic                 out_load;

    assign out_load = advance && res_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_kind_reg   <= res_kind;
            out_byte_reg   <= res_byte;
            out_status_reg <= res_status;
            out_type_reg   <= res_type;
            out_plen_reg   <= res_plen;
            out_fbytes_reg <= res_fbytes;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = out_kind_reg;
    assign m_payload_byte   = out_byte_reg;
    assign m_status         = out_status_reg;
    assign m_packet_type    = out_type_reg;
    assign m_payload_length = out_plen_reg;
    assign m_frame_bytes    = out_fbytes_reg;

endmodule

>>> src/spd_checker.sv
// ----------------------------------------------------------------------------
// spd_checker
// Port-level checks on the deframer result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "sum16_packet_deframer_unit_defines.svh"

module spd_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_kind,
    input  logic [spd_pkg::BYTE_W-1:0]      m_payload_byte,
    input  logic [spd_pkg::STATUS_W-1:0]    m_status,
    input  logic [spd_pkg::BYTE_W-1:0]      m_packet_type,
    input  logic [spd_pkg::OUT_LEN_W-1:0]   m_payload_length,
    input  logic [spd_pkg::OUT_LEN_W-1:0]   m_frame_bytes
);
    import spd_pkg::*;

    `SPD_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_valid, "result valid after reset")

    `SPD_ASSERT(a_payload_clean,
        m_valid && m_kind == KIND_PAYLOAD |-> m_status == STATUS_OK &&
        m_packet_type == '0 && m_payload_length == '0 && m_frame_bytes == '0,
        "payload item carries status fields")

    `SPD_ASSERT(a_fail_clean,
        m_valid && m_kind == KIND_STATUS && m_status != STATUS_OK |->
        m_payload_byte == '0 && m_packet_type == '0 && m_payload_length == '0 &&
        m_frame_bytes == '0 && (m_status == STATUS_FRAME_ERROR ||
        m_status == STATUS_BAD_PACKET),
        "failed status carries stray fields")

    `SPD_ASSERT(a_ok_lengths,
        m_valid && m_kind == KIND_STATUS && m_status == STATUS_OK |->
        m_frame_bytes == OUT_LEN_W'(m_payload_length + OUT_LEN_W'(MIN_BUFFER)) &&
        m_payload_byte == '0,
        "frame byte count disagrees with payload length")

    `SPD_ASSERT(a_stall_hold,
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_payload_byte) &&
        $stable(m_status),
        "stalled result changed")

endmodule

bind sum16_packet_deframer_unit spd_checker u_spd_checker (.*);
